[sv/bwfa_pkg.sv]
// bwfa_pkg: types and fixed field constants of the best/worst fit allocator
// no dependencies; imported by best_worst_fit_allocator_unit and the testbench

package bwfa_pkg;

   localparam int INDEX_BITS    = 4;
   localparam int AMOUNT_BITS   = 16;
   localparam int ACTIVE_BITS   = 5;
   localparam int TDATA_BITS    = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 5'd16;

   // request kinds carried on tuser
   localparam logic TYPE_LOAD  = 1'b0;
   localparam logic TYPE_ALLOC = 1'b1;

   // register select taken from paddr[2]
   localparam logic CSR_SEL_FIT_MODE = 1'b0;
   localparam logic CSR_SEL_ACTIVE   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[sv/best_worst_fit_allocator_unit.sv]
// best_worst_fit_allocator_unit: capacity table with best/worst fit allocation
// depends on bwfa_pkg and bwfa_ram
//
//   channel   direction  handshake             contents
//   req_*     in         tvalid/tready         tuser kind, tdata block index and amount
//   rsp_*     out        tvalid/tready         tuser granted, tdata block and capacity left
//   csr_*     in         psel/penable/pready   fit mode, active block count
//
// a load answers in the cycle after it is taken; an allocate answers once the scan,
// reading one table entry per cycle through the ram read port, has passed the
// active blocks and the chosen entry is written back in ST_DONE.
// reset clears per-entry valid bits at once, so there is no clearing pass.
// a waiting response does not hold up a scan; a new request is taken only
// while the response register is free or being emptied in the same cycle.

module best_worst_fit_allocator_unit
   import bwfa_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [TDATA_BITS-1:0]    req_tdata,   // [3:0] block_index, [19:4] amount
   input  logic                     req_tuser,   // [0] req_type
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [TDATA_BITS-1:0]    rsp_tdata,   // [3:0] chosen_block, [19:4] capacity_left
   output logic                     rsp_tuser,   // [0] granted
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int LW = $clog2(NUM_BLOCKS + 1);

   state_type state_ff, state_in;

   logic                   fit_mode_ff, fit_mode_in;
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [NUM_BLOCKS-1:0]  valid_ff, valid_in;

   logic [LW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                   cmp_ok_ff, cmp_ok_in;
   logic [SIZE_BITS-1:0]   amt_ff, amt_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          pick_ff, pick_in;
   logic [SIZE_BITS-1:0]   pick_cap_ff, pick_cap_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [INDEX_BITS-1:0]  rsp_block_ff, rsp_block_in;
   logic [AMOUNT_BITS-1:0] rsp_cap_ff, rsp_cap_in;

   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic [SIZE_BITS-1:0]   rd_data;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [SIZE_BITS-1:0]   wr_data;

   logic [LW-1:0]          limit;
   logic                   csr_write;
   logic                   req_fire;
   logic                   out_free;
   logic [INDEX_BITS-1:0]  req_index;
   logic [SIZE_BITS-1:0]   req_amount;

   assign req_index  = req_tdata[INDEX_BITS-1:0];
   assign req_amount = SIZE_BITS'(req_tdata[INDEX_BITS +: AMOUNT_BITS]);
   assign limit      = (32'(active_ff) > NUM_BLOCKS) ? LW'(NUM_BLOCKS) : LW'(active_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   bwfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_cap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      fit_mode_in = fit_mode_ff;
      active_in   = active_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_SEL_FIT_MODE: fit_mode_in = csr_pwdata[0];
            CSR_SEL_ACTIVE:   active_in   = csr_pwdata[ACTIVE_BITS-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_SEL_FIT_MODE: csr_prdata = CSR_DATA_BITS'(fit_mode_ff);
         CSR_SEL_ACTIVE:   csr_prdata = CSR_DATA_BITS'(active_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // sequencer: load, scan one entry per cycle, write back and respond
   always_comb begin
      logic [SIZE_BITS-1:0] cur_cap;
      logic                 fits;
      logic                 better;

      cur_cap = cmp_ok_ff ? rd_data : '0;
      fits    = cur_cap >= amt_ff;
      better  = fit_mode_ff ? (pick_cap_ff <= cur_cap) : (pick_cap_ff >= cur_cap);

      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = rd_idx_ff[IW-1:0];
      cmp_ok_in      = valid_ff[rd_idx_ff[IW-1:0]];
      amt_in         = amt_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      pick_cap_in    = pick_cap_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_cap_in     = rsp_cap_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff[IW-1:0];
      wr_en          = 1'b0;
      wr_addr        = pick_ff;
      wr_data        = pick_cap_ff - amt_ff;
      valid_in       = valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == TYPE_ALLOC) begin
                  amt_in    = req_amount;
                  rd_idx_in = '0;
                  found_in  = 1'b0;
                  state_in  = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (32'(req_index) < NUM_BLOCKS) begin
                     wr_en          = 1'b1;
                     wr_addr        = IW'(req_index);
                     wr_data        = req_amount;
                     rsp_granted_in = 1'b1;
                     rsp_block_in   = req_index;
                     rsp_cap_in     = AMOUNT_BITS'(req_amount);
                  end else begin
                     rsp_granted_in = 1'b0;
                     rsp_block_in   = '0;
                     rsp_cap_in     = '0;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < limit) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               rd_idx_in    = rd_idx_ff + LW'(1);
            end
            if (cmp_valid_ff && fits && (!found_ff || better)) begin
               found_in    = 1'b1;
               pick_in     = cmp_idx_ff;
               pick_cap_in = cur_cap;
            end
            if (!(rd_idx_ff < limit) && !cmp_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found_ff) begin
                  wr_en          = 1'b1;
                  rsp_granted_in = 1'b1;
                  rsp_block_in   = INDEX_BITS'(pick_ff);
                  rsp_cap_in     = AMOUNT_BITS'(wr_data);
               end else begin
                  rsp_granted_in = 1'b0;
                  rsp_block_in   = '0;
                  rsp_cap_in     = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fit_mode_ff  <= 1'b0;
         active_ff    <= ACTIVE_RESET;
         valid_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fit_mode_ff  <= fit_mode_in;
         active_ff    <= active_in;
         valid_ff     <= valid_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      cmp_ok_ff      <= cmp_ok_in;
      amt_ff         <= amt_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      pick_cap_ff    <= pick_cap_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_cap_ff     <= rsp_cap_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = TDATA_BITS'({rsp_cap_ff, rsp_block_ff});

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (state_ff == ST_SCAN) && (rd_idx_ff < limit))
      else $error("table read beyond active blocks");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && found_ff |-> pick_cap_ff >= amt_ff)
      else $error("chosen block smaller than request");

   a_pick_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && found_ff |-> 32'(pick_ff) < 32'(limit))
      else $error("chosen block outside active range");

   a_alloc_scans: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == TYPE_ALLOC) |=> state_ff == ST_SCAN)
      else $error("allocate request did not start a scan");

   a_write_not_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != ST_SCAN)
      else $error("table written during scan");

endmodule

[sv/bwfa_ram.sv]
// bwfa_ram: generic single write, single read memory with registered read data
// no dependencies

module bwfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for best_worst_fit_allocator_unit, directed then random requests
// depends on bwfa_pkg and the allocator rtl; keeps its own capacity table to predict each response

module testbench;
   import bwfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES    = 16;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_REQUESTS = 45;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FIT_MODE = {CSR_SEL_FIT_MODE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_ACTIVE   = {CSR_SEL_ACTIVE, 2'b00};

   localparam logic FIT_BEST  = 1'b0;
   localparam logic FIT_WORST = 1'b1;

   typedef struct packed {
      logic                   granted;
      logic [INDEX_BITS-1:0]  block;
      logic [AMOUNT_BITS-1:0] cap_left;
   } alloc_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [TDATA_BITS-1:0]    req_tdata = '0;   // [3:0] block_index, [19:4] amount
   logic                     req_tuser = 1'b0; // [0] req_type
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0]    rsp_tdata;        // [3:0] chosen_block, [19:4] capacity_left
   logic                     rsp_tuser;        // [0] granted
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   logic [AMOUNT_BITS-1:0] capacity_table [NUM_ENTRIES];
   logic                   fit_mode_q;
   logic [ACTIVE_BITS-1:0] active_count_q;
   alloc_result_type       pending_results [$];
   int unsigned            mismatches = 0;
   bit                     req_idle_on = 1'b0;
   bit                     rsp_stall_on = 1'b0;
   int unsigned            stall_left = 0;
   int unsigned            idle_cycles = 0;

   best_worst_fit_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void record_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
      end
   endfunction

   // updates the capacity table and returns the response a request should produce
   function automatic alloc_result_type apply_request(logic kind, logic [INDEX_BITS-1:0] idx,
                                                      logic [AMOUNT_BITS-1:0] amt);
      alloc_result_type res;
      int unsigned      limit;
      int unsigned      pick;
      bit               found;
      res = '0;
      if (kind == TYPE_LOAD) begin
         capacity_table[idx] = amt;
         res.granted  = 1'b1;
         res.block    = idx;
         res.cap_left = amt;
         return res;
      end
      limit = (active_count_q > NUM_ENTRIES) ? NUM_ENTRIES : active_count_q;
      found = 1'b0;
      pick  = 0;
      for (int unsigned j = 0; j < limit; j++) begin
         if (capacity_table[j] >= amt) begin
            if (!found) begin
               found = 1'b1;
               pick  = j;
            end else if (fit_mode_q == FIT_WORST) begin
               if (capacity_table[pick] <= capacity_table[j]) pick = j;
            end else begin
               if (capacity_table[pick] >= capacity_table[j]) pick = j;
            end
         end
      end
      if (found) begin
         capacity_table[pick] = capacity_table[pick] - amt;
         res.granted  = 1'b1;
         res.block    = pick[INDEX_BITS-1:0];
         res.cap_left = capacity_table[pick];
      end
      return res;
   endfunction

   function automatic int unsigned random_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 90) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [AMOUNT_BITS-1:0] load_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return AMOUNT_BITS'($urandom_range(0, 1023));
      if (r < 70) return AMOUNT_BITS'($urandom_range(0, 65535));
      if (r < 80) return 16'hFFFF;
      if (r < 85) return 16'h0000;
      return capacity_table[$urandom_range(0, NUM_ENTRIES-1)];
   endfunction

   function automatic logic [AMOUNT_BITS-1:0] request_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h0000;
      if (r < 30) return AMOUNT_BITS'($urandom_range(0, 255));
      if (r < 50) return capacity_table[$urandom_range(0, NUM_ENTRIES-1)];
      if (r < 70) return capacity_table[$urandom_range(0, NUM_ENTRIES-1)] >> $urandom_range(1, 4);
      return AMOUNT_BITS'($urandom_range(0, 65535));
   endfunction

   task automatic send_request(input logic kind, input logic [INDEX_BITS-1:0] idx,
                               input logic [AMOUNT_BITS-1:0] amt);
      int unsigned gap;
      gap = (req_idle_on && $urandom_range(0, 99) < 40) ? random_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(TDATA_BITS-INDEX_BITS-AMOUNT_BITS){1'b0}}, amt, idx};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_request(kind, idx, amt));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] addr, input int unsigned value);
      int unsigned field_mask;
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_FIT_MODE) begin
         field_mask = 32'h1;
         fit_mode_q = value[0];
      end else begin
         field_mask = 32'h1F;
         active_count_q = value[ACTIVE_BITS-1:0];
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & field_mask) != (value & field_mask)) begin
         record_mismatch("register readback", value & field_mask, csr_prdata & field_mask);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_reset_state();
      // all capacities zero: a zero-size request fits everywhere, the highest index wins
      send_request(TYPE_ALLOC, 4'h0, 16'h0000);
      send_request(TYPE_ALLOC, 4'hF, 16'h0001);
   endtask

   task automatic test_load_extremes();
      send_request(TYPE_LOAD, 4'h0, 16'hFFFF);
      send_request(TYPE_LOAD, 4'hF, 16'hFFFF);
      send_request(TYPE_LOAD, 4'hA, 16'hAAAA);
      send_request(TYPE_LOAD, 4'h5, 16'h5555);
      send_request(TYPE_LOAD, 4'h3, 16'h0001);
   endtask

   task automatic test_best_fit();
      write_register(ADDR_FIT_MODE, FIT_BEST);
      send_request(TYPE_ALLOC, 4'h7, 16'h0001);
      send_request(TYPE_ALLOC, 4'h0, 16'h5555);
      send_request(TYPE_ALLOC, 4'h0, 16'h1000);
      send_request(TYPE_ALLOC, 4'h0, 16'hFFFF);
      send_request(TYPE_ALLOC, 4'h0, 16'hFFFF);
      send_request(TYPE_ALLOC, 4'h0, 16'hF000);
   endtask

   task automatic test_worst_fit();
      write_register(ADDR_FIT_MODE, FIT_WORST);
      send_request(TYPE_LOAD, 4'h2, 16'h9AAA);
      send_request(TYPE_ALLOC, 4'h0, 16'h0010);
      send_request(TYPE_ALLOC, 4'h0, 16'h0000);
      send_request(TYPE_ALLOC, 4'h0, 16'h9AAB);
   endtask

   task automatic test_active_count();
      write_register(ADDR_ACTIVE, 1);
      send_request(TYPE_ALLOC, 4'h0, 16'h0000);
      send_request(TYPE_ALLOC, 4'h0, 16'h0001);
      write_register(ADDR_ACTIVE, 0);
      send_request(TYPE_ALLOC, 4'h0, 16'h0000);
      write_register(ADDR_ACTIVE, 31);
      send_request(TYPE_ALLOC, 4'h0, 16'h0000);
      write_register(ADDR_ACTIVE, 17);
      send_request(TYPE_ALLOC, 4'h0, 16'h0001);
   endtask

   task automatic test_random_traffic();
      int unsigned mode_list [10];
      int unsigned count_list [10];
      mode_list  = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
      count_list = '{16, 16, 1, 1, 8, 5, 0, 31, 17, 12};
      for (int p = 0; p < 10; p++) begin
         write_register(ADDR_FIT_MODE, mode_list[p]);
         write_register(ADDR_ACTIVE, count_list[p]);
         req_idle_on  = (p % 3) != 0;
         rsp_stall_on = (p % 3) != 1;
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            if ($urandom_range(0, 99) < 35) begin
               send_request(TYPE_LOAD, INDEX_BITS'($urandom_range(0, NUM_ENTRIES-1)),
                            load_value());
            end else begin
               send_request(TYPE_ALLOC, INDEX_BITS'($urandom_range(0, NUM_ENTRIES-1)),
                            request_size());
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_stall_on && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         stall_left <= random_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            record_mismatch("response with none pending", 0, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser != want.granted) begin
               record_mismatch("granted", want.granted, rsp_tuser);
            end
            if (rsp_tdata[INDEX_BITS-1:0] != want.block) begin
               record_mismatch("chosen_block", want.block, rsp_tdata[INDEX_BITS-1:0]);
            end
            if (rsp_tdata[INDEX_BITS +: AMOUNT_BITS] != want.cap_left) begin
               record_mismatch("capacity_left", want.cap_left,
                               rsp_tdata[INDEX_BITS +: AMOUNT_BITS]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) capacity_table[i] = '0;
      fit_mode_q     = FIT_BEST;
      active_count_q = ACTIVE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_load_extremes();
      test_best_fit();
      test_worst_fit();
      test_active_count();
      write_register(ADDR_ACTIVE, 16);
      test_random_traffic();
      drain_results();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
